>>> sv/ogru_pkg.sv
package ogru_pkg;

	localparam int COORD_W = 13;
	localparam int DIFF_W  = 14;
	localparam int ERR_W   = 17;
	localparam int CFG_W   = 10;
	localparam int VAL_W   = 8;
	localparam int CELL_W  = 2;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(400);
	localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(400);

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic CMD_RAY  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic KIND_RAY_DONE = 1'b0;
	localparam logic KIND_READ     = 1'b1;

	localparam logic [CELL_W-1:0] CELL_UNKNOWN = 2'd0;
	localparam logic [CELL_W-1:0] CELL_FREE    = 2'd1;
	localparam logic [CELL_W-1:0] CELL_OCC     = 2'd2;

	localparam logic signed [VAL_W-1:0] VAL_UNKNOWN = -8'sd1;
	localparam logic signed [VAL_W-1:0] VAL_FREE    = 8'sd0;
	localparam logic signed [VAL_W-1:0] VAL_OCC     = 8'sd100;

	typedef struct packed {
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
	} ogru_dims_t;

	typedef struct packed {
		logic                       cmd;
		logic                       hit_in;
		logic                       robot_in;
		logic                       zero_len;
		logic signed [COORD_W-1:0]  rx;
		logic signed [COORD_W-1:0]  ry;
		logic signed [COORD_W-1:0]  hx;
		logic signed [COORD_W-1:0]  hy;
		logic [DIFF_W-1:0]          dx;
		logic [DIFF_W-1:0]          dy;
		logic                       sx_neg;
		logic                       sy_neg;
	} ogru_item_t;

	function automatic logic in_map(
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input ogru_dims_t                dims
	);
		in_map = !x[COORD_W-1] && !y[COORD_W-1] &&
			($unsigned(x) < dims.w) && ($unsigned(y) < dims.h);
	endfunction

endpackage

>>> sv/ogru_ram.sv
module ogru_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> sv/ogru_front.sv
module ogru_front
	import ogru_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  ogru_dims_t                 dims,
	input  logic                       hold,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic signed [COORD_W-1:0]  robot_x,
	input  logic signed [COORD_W-1:0]  robot_y,
	input  logic signed [COORD_W-1:0]  hit_x,
	input  logic signed [COORD_W-1:0]  hit_y,
	output logic                       q_valid,
	input  logic                       q_ready,
	output ogru_item_t                 q_item
);

	localparam int QDEPTH = 2;

	ogru_item_t                item;
	ogru_item_t                entry_q [QDEPTH];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                count_q;
	logic                      push;
	logic                      pop;
	logic signed [DIFF_W-1:0]  diff_x;
	logic signed [DIFF_W-1:0]  diff_y;

	// Classify the word on the way in: map membership, deltas and step signs.
	always_comb begin
		diff_x = DIFF_W'(hit_x) - DIFF_W'(robot_x);
		diff_y = DIFF_W'(hit_y) - DIFF_W'(robot_y);
		item.cmd      = cmd;
		item.hit_in   = in_map(hit_x, hit_y, dims);
		item.robot_in = in_map(robot_x, robot_y, dims);
		item.zero_len = (robot_x == hit_x) && (robot_y == hit_y);
		item.rx       = robot_x;
		item.ry       = robot_y;
		item.hx       = hit_x;
		item.hy       = hit_y;
		item.dx       = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
		item.dy       = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
		item.sx_neg   = !(robot_x < hit_x);
		item.sy_neg   = !(robot_y < hit_y);
	end

	assign in_ready = !hold && (count_q != 2'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

endmodule

>>> sv/ogru_back.sv
module ogru_back
	import ogru_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ogru_dims_t                dims,
	output logic                      clearing,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  ogru_item_t                q_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      result_kind,
	output logic signed [VAL_W-1:0]   cell_value
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WALK
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              clr_q;
	logic                       out_valid_q;
	logic                       kind_q;
	logic signed [VAL_W-1:0]    value_q;
	logic signed [COORD_W-1:0]  cx_q;
	logic signed [COORD_W-1:0]  cy_q;
	logic signed [COORD_W-1:0]  x1_q;
	logic signed [COORD_W-1:0]  y1_q;
	logic [DIFF_W-1:0]          dx_q;
	logic [DIFF_W-1:0]          dy_q;
	logic                       sx_neg_q;
	logic                       sy_neg_q;
	logic signed [ERR_W-1:0]    err_q;

	logic                       slot_free;
	logic                       take;
	logic                       result_set;
	logic signed [ERR_W:0]      e2;
	logic                       step_x;
	logic                       step_y;
	logic signed [ERR_W-1:0]    err_nx;
	logic signed [COORD_W-1:0]  cx_nx;
	logic signed [COORD_W-1:0]  cy_nx;
	logic signed [COORD_W-1:0]  ram_x;
	logic signed [COORD_W-1:0]  ram_y;
	logic                       ram_en;
	logic                       ram_we;
	logic [AW-1:0]              ram_addr;
	logic [CELL_W-1:0]          ram_wdata;
	logic [CELL_W-1:0]          ram_rdata;
	logic signed [VAL_W-1:0]    read_value;

	assign clearing    = (state_q == ST_CLEAR);
	assign slot_free   = !out_valid_q || out_ready;
	assign q_ready     = (state_q == ST_IDLE) && slot_free;
	assign take        = q_valid && q_ready;
	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign cell_value  = value_q;

	always_comb begin
		e2     = {err_q, 1'b0};
		step_x = e2 > -$signed((ERR_W+1)'(dy_q));
		step_y = e2 < $signed((ERR_W+1)'(dx_q));
		err_nx = err_q - (step_x ? ERR_W'(dy_q) : ERR_W'(0))
			+ (step_y ? ERR_W'(dx_q) : ERR_W'(0));
		cx_nx  = cx_q;
		cy_nx  = cy_q;
		if (step_x) begin
			cx_nx = sx_neg_q ? cx_q - COORD_W'(1) : cx_q + COORD_W'(1);
		end
		if (step_y) begin
			cy_nx = sy_neg_q ? cy_q - COORD_W'(1) : cy_q + COORD_W'(1);
		end
	end

	always_comb begin
		result_set = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (q_item.cmd == CMD_READ) begin
						result_set = !q_item.hit_in;
					end else begin
						result_set = !(q_item.robot_in && !q_item.zero_len);
					end
				end
			end
			ST_READ: begin
				result_set = 1'b1;
			end
			ST_WALK: begin
				result_set = (cx_nx == x1_q) && (cy_nx == y1_q);
			end
			default: begin
				result_set = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_x     = (state_q == ST_WALK) ? cx_q : q_item.hx;
		ram_y     = (state_q == ST_WALK) ? cy_q : q_item.hy;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = CELL_UNKNOWN;
		ram_addr  = AW'(ram_y[YW-1:0]) * AW'(MAX_WIDTH) + AW'(ram_x[XW-1:0]);
		case (state_q)
			ST_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_IDLE: begin
				if (take && q_item.hit_in) begin
					ram_en    = 1'b1;
					ram_we    = (q_item.cmd == CMD_RAY);
					ram_wdata = CELL_OCC;
				end
			end
			ST_WALK: begin
				if (in_map(cx_q, cy_q, dims)) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_wdata = CELL_FREE;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (ram_rdata)
			CELL_FREE: read_value = VAL_FREE;
			CELL_OCC:  read_value = VAL_OCC;
			default:   read_value = VAL_UNKNOWN;
		endcase
	end

	ogru_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= result_set || (out_valid_q && !out_ready);
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						if (q_item.cmd == CMD_READ) begin
							if (q_item.hit_in) begin
								state_q <= ST_READ;
							end else begin
								kind_q  <= KIND_READ;
								value_q <= VAL_UNKNOWN;
							end
						end else if (q_item.robot_in && !q_item.zero_len) begin
							state_q <= ST_WALK;
						end else begin
							kind_q  <= KIND_RAY_DONE;
							value_q <= VAL_FREE;
						end
					end
				end
				ST_READ: begin
					kind_q  <= KIND_READ;
					value_q <= read_value;
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if ((cx_nx == x1_q) && (cy_nx == y1_q)) begin
						kind_q  <= KIND_RAY_DONE;
						value_q <= VAL_FREE;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cx_q     <= q_item.rx;
			cy_q     <= q_item.ry;
			x1_q     <= q_item.hx;
			y1_q     <= q_item.hy;
			dx_q     <= q_item.dx;
			dy_q     <= q_item.dy;
			sx_neg_q <= q_item.sx_neg;
			sy_neg_q <= q_item.sy_neg;
			err_q    <= ERR_W'(q_item.dx) - ERR_W'(q_item.dy);
		end else if (state_q == ST_WALK) begin
			cx_q  <= cx_nx;
			cy_q  <= cy_nx;
			err_q <= err_nx;
		end
	end

endmodule

>>> sv/occupancy_grid_ray_update.sv
// Occupancy grid with a line-walk ray update. A ray word marks an in-map hit
// cell occupied and, if the robot cell is in the map and differs from it,
// walks from the robot cell toward it, marking every in-map cell free except
// the end cell; a read word returns one cell as -1, 0 or 100. After reset
// the grid is swept to unknown, one cell per cycle over all MAX_WIDTH *
// MAX_HEIGHT cells (262144 at the defaults), and no word is taken until the
// sweep ends; configuration writes are taken throughout. A read of an in-map
// cell goes through the READ state; any other read is answered from IDLE. The
// ray walk writes one cell per cycle on the single grid memory port. A
// two-word queue lets new words arrive while a ray is walked or a result waits.
module occupancy_grid_ray_update
	import ogru_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] robot_x,
	input  logic signed [COORD_W-1:0] robot_y,
	input  logic signed [COORD_W-1:0] hit_x,
	input  logic signed [COORD_W-1:0] hit_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      result_kind,
	output logic signed [VAL_W-1:0]   cell_value
);

	logic [CFG_W-1:0] grid_width_q;
	logic [CFG_W-1:0] grid_height_q;
	ogru_dims_t       dims;
	logic             clearing;
	logic             q_valid;
	logic             q_ready;
	ogru_item_t       q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= RESET_WIDTH;
			grid_height_q <= RESET_HEIGHT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		dims.w = (COORD_W'(grid_width_q) > COORD_W'(MAX_WIDTH)) ?
			COORD_W'(MAX_WIDTH) : COORD_W'(grid_width_q);
		dims.h = (COORD_W'(grid_height_q) > COORD_W'(MAX_HEIGHT)) ?
			COORD_W'(MAX_HEIGHT) : COORD_W'(grid_height_q);
	end

	ogru_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.dims    (dims),
		.hold    (clearing),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.robot_x (robot_x),
		.robot_y (robot_y),
		.hit_x   (hit_x),
		.hit_y   (hit_y),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	ogru_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.clearing   (clearing),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_kind(result_kind),
		.cell_value (cell_value)
	);

endmodule
